// ===== rtl/lfid_pkg.sv =====
// Shared constants, codes and types for the lowest-free id allocator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package lfid_pkg;

	// table geometry; slot 0 is never handed out
	localparam int SLOTS     = 64;
	localparam int SLOT_W    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int CHUNK     = 8;                       // used marks examined per scan cycle
	localparam int NCHUNK    = (SLOTS + CHUNK - 1) / CHUNK;
	localparam int SCAN_W    = NCHUNK * CHUNK;
	localparam int SCAN_IW   = $clog2(SCAN_W);
	localparam int CNT_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int OFF_W     = $clog2(CHUNK);

	// item field widths
	localparam int ACTION_W  = 3;
	localparam int ID_W      = 6;
	localparam int STATUS_W  = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC   = 3'd0,
		ACT_FREE    = 3'd1,
		ACT_TEST    = 3'd2,
		ACT_READ_EN = 3'd3,
		ACT_SET_EN  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BAD_ID = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	// result of one scan step
	typedef struct packed {
		logic               found;
		logic [SCAN_IW-1:0] slot;
	} scan_res_t;

endpackage
`default_nettype wire

// ===== rtl/lowest_free_id_allocator_core.sv =====
// Lowest-free id allocator: each item is one request (allocate, free, test,
// read enable, set enable) and yields exactly one result item. Allocation
// walks the used marks eight slots per cycle through one shared scan unit,
// so an allocate steps through one scan state per chunk up to the chunk that
// holds the lowest free slot (every chunk when the table is full) and then a
// finishing state that loads the output register. Other requests go through a
// lookup state, set by the registered read of the enable RAM, and then the
// finishing state. s_tready is high only between requests; a finished result
// waits in the output register while the next request is taken, and that
// request holds in its last cycle until the output register is free.
// Depends on lfid_pkg, lfid_scan and lfid_en_ram.
`default_nettype none
module lowest_free_id_allocator_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lfid_pkg::IN_TDATA_W-1:0]   s_tdata,  // slot_id[5:0], enable_value[6]
	input  wire logic [lfid_pkg::ACTION_W-1:0]     s_tuser,  // action[2:0]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [lfid_pkg::OUT_TDATA_W-1:0]       m_tdata   // given_id[5:0], is_valid[6],
	                                                         // is_enabled[7], status[9:8]
);
	import lfid_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LOOK = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [ACTION_W-1:0]   action_q;
	logic [ID_W-1:0]       slot_id_q;
	logic                  enable_value_q;
	logic [CNT_W-1:0]      chunk_q;
	logic                  found_q;
	logic [SCAN_IW-1:0]    slot_q;
	logic [SLOTS-1:0]      used_q;

	logic [SCAN_W-1:0]     occ;
	scan_res_t             scan_res;
	logic                  accept;
	logic                  out_free;
	logic                  finish;
	logic                  in_range;
	logic [SLOT_W-1:0]     id_idx;
	logic                  id_ok;
	logic                  ram_rdata;

	// result fields and side effects of the finishing cycle
	logic [ID_W-1:0]       given_id;
	logic                  is_valid;
	logic                  is_enabled;
	status_t               status;
	logic                  set_used;
	logic                  clr_used;
	logic                  ram_we;
	logic                  ram_wdata;
	logic [SLOT_W-1:0]     wr_idx;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign finish   = (state_q == S_FIN) && out_free;

	// slot 0 and padding beyond the table always look occupied to the scan
	always_comb begin
		for (int i = 0; i < SCAN_W; i++) begin
			if (i == 0 || i >= SLOTS) begin
				occ[i] = 1'b1;
			end else begin
				occ[i] = used_q[i];
			end
		end
	end

	lfid_scan u_scan (
		.occ   (occ),
		.chunk (chunk_q),
		.res   (scan_res)
	);

	assign in_range = (slot_id_q != '0) && (int'(slot_id_q) < SLOTS);
	assign id_idx   = SLOT_W'(slot_id_q);
	assign id_ok    = in_range && used_q[id_idx];

	always_comb begin
		given_id   = '0;
		is_valid   = 1'b0;
		is_enabled = 1'b0;
		status     = STAT_OK;
		set_used   = 1'b0;
		clr_used   = 1'b0;
		ram_we     = 1'b0;
		ram_wdata  = 1'b0;
		wr_idx     = id_idx;
		unique case (action_q)
			ACT_ALLOC: begin
				wr_idx = SLOT_W'(slot_q);
				if (found_q) begin
					given_id   = ID_W'(slot_q);
					is_valid   = 1'b1;
					is_enabled = 1'b1;
					set_used   = 1'b1;
					ram_we     = 1'b1;
					ram_wdata  = 1'b1;
				end else begin
					status = STAT_FULL;
				end
			end
			ACT_FREE: begin
				if (id_ok) begin
					clr_used = 1'b1;
					ram_we   = 1'b1;
				end else begin
					status = STAT_BAD_ID;
				end
			end
			ACT_TEST: begin
				is_valid = id_ok;
			end
			ACT_READ_EN: begin
				if (id_ok) begin
					is_valid   = 1'b1;
					is_enabled = ram_rdata;
				end else begin
					status = STAT_BAD_ID;
				end
			end
			ACT_SET_EN: begin
				if (id_ok) begin
					is_valid   = 1'b1;
					is_enabled = enable_value_q;
					ram_we     = 1'b1;
					ram_wdata  = enable_value_q;
				end else begin
					status = STAT_BAD_ID;
				end
			end
			default: begin
			end
		endcase
	end

	lfid_en_ram u_en_ram (
		.clk   (clk),
		.we    (finish && ram_we),
		.waddr (wr_idx),
		.wdata (ram_wdata),
		.raddr (id_idx),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chunk_q <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						chunk_q <= '0;
						found_q <= 1'b0;
						if (s_tuser == ACT_ALLOC) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_SCAN: begin
					if (scan_res.found) begin
						found_q <= 1'b1;
						state_q <= S_FIN;
					end else if (chunk_q == CNT_W'(NCHUNK - 1)) begin
						state_q <= S_FIN;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_LOOK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields and found slot
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q       <= s_tuser;
			slot_id_q      <= s_tdata[ID_W-1:0];
			enable_value_q <= s_tdata[ID_W];
		end
		if (state_q == S_SCAN && scan_res.found) begin
			slot_q <= scan_res.slot;
		end
	end

	// used marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (finish) begin
			if (set_used) begin
				used_q[wr_idx] <= 1'b1;
			end else if (clr_used) begin
				used_q[wr_idx] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata <= {{(OUT_TDATA_W - ID_W - 2 - STATUS_W){1'b0}},
				status, is_enabled, is_valid, given_id};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lfid_scan.sv =====
// Scan step of the allocator: picks one chunk of the occupancy vector and
// returns the lowest free slot in it. Depends on lfid_pkg.
`default_nettype none
module lfid_scan (
	input  wire logic [lfid_pkg::SCAN_W-1:0] occ,
	input  wire logic [lfid_pkg::CNT_W-1:0]  chunk,
	output lfid_pkg::scan_res_t              res
);
	import lfid_pkg::*;

	logic [CHUNK-1:0] bits;
	logic             found;
	logic [OFF_W-1:0] off;

	assign bits = occ[chunk * CHUNK +: CHUNK];

	// priority encoder, lowest clear bit wins
	always_comb begin
		found = 1'b0;
		off   = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				found = 1'b1;
				off   = OFF_W'(i);
			end
		end
	end

	assign res.found = found;
	assign res.slot  = (SCAN_IW'(chunk) << OFF_W) | SCAN_IW'(off);

endmodule
`default_nettype wire

// ===== rtl/lfid_en_ram.sv =====
// Enable marks, one bit per slot, single write port and one registered read.
// Read data is only used for slots in use, so no reset is needed. Depends on lfid_pkg.
`default_nettype none
module lfid_en_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [lfid_pkg::SLOT_W-1:0] waddr,
	input  wire logic                       wdata,
	input  wire logic [lfid_pkg::SLOT_W-1:0] raddr,
	output logic                            rdata
);
	import lfid_pkg::*;

	logic mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
